@@ sv/hks_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hks_pkg
// Shared types and constants for the heartbeat keepalive supervisor.
// ---------------------------------------------------------------------------
package hks_pkg;

    // Time stamps and deadlines
    localparam int TIME_WIDTH = 48;

    // Configuration register widths
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int MISS_WIDTH      = 8;

    localparam logic [MISS_WIDTH-1:0] MISS_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HEARTBEAT_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RECONNECT_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MISS_LIMIT         = 2'd2;

    // Configuration reset values
    localparam logic [CFG_DATA_WIDTH-1:0] HEARTBEAT_INTERVAL_RST = 32'd1000;
    localparam logic [CFG_DATA_WIDTH-1:0] RECONNECT_INTERVAL_RST = 32'd2000;
    localparam logic [MISS_WIDTH-1:0]     MISS_LIMIT_RST         = 8'd3;

    // Event kinds
    typedef enum logic [1:0] {
        OP_CONNECT    = 2'd0,
        OP_RESPONSE   = 2'd1,
        OP_DISCONNECT = 2'd2,
        OP_POLL       = 2'd3
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONN_ADD,
        S_NRC_ADD,
        S_RC_CMP,
        S_HB_CMP,
        S_HB_STEP,
        S_DONE
    } state_t;

endpackage : hks_pkg
`default_nettype wire

@@ sv/heartbeat_keepalive_supervisor.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// heartbeat_keepalive_supervisor
// Link keepalive supervisor: tracks connect/alive state, missed heartbeats
// and heartbeat/reconnect deadlines from time-stamped events.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+-------------------------------
//  in       | input     | in_valid / in_stall | operation, now_ms
//  out      | output    | out_valid/out_stall | send_heartbeat .. miss_count
//  cfg      | input     | cfg_write           | cfg_index, cfg_data
//
//  Steps: a response goes straight to the done step; connect adds the
//  heartbeat deadline and disconnect the reconnect deadline; a poll while
//  disconnected compares the reconnect deadline and adds a new one when a
//  reconnect is due; a poll while connected compares and steps once per
//  overdue heartbeat interval (at most miss_limit + 1 intervals). One
//  49-bit unit does all deadline sums and compares, one operation per cycle.
//  Reset (rst_n low) clears the link flags, the miss count, both deadlines
//  and loads the configuration defaults; no clearing pass is needed.
//  in_stall is high while a transaction is in work; a stalled result
//  holds the last step until the output register frees up.
// ---------------------------------------------------------------------------
module heartbeat_keepalive_supervisor
    import hks_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    // Configuration write port
    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,

    // Event input
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 operation,
    input  wire logic [TIME_WIDTH-1:0]      now_ms,

    // Result output
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            send_heartbeat,
    output logic                            send_initial_status,
    output logic                            connection_changed,
    output logic                            reconnect_request,
    output logic                            heartbeat_lost,
    output logic                            is_connected,
    output logic                            is_alive,
    output logic [MISS_WIDTH-1:0]           miss_count
);

    // Sequencer and link state
    state_t                    state_reg, state_next;
    logic                      conn_reg, conn_next;
    logic                      alive_reg, alive_next;
    logic                      awaiting_reg, awaiting_next;
    logic [MISS_WIDTH-1:0]     misses_reg, misses_next;
    logic [TIME_WIDTH-1:0]     nhb_reg, nhb_next;
    logic [TIME_WIDTH-1:0]     nrc_reg, nrc_next;

    // Configuration
    logic [CFG_DATA_WIDTH-1:0] hbi_reg, hbi_next;
    logic [CFG_DATA_WIDTH-1:0] rci_reg, rci_next;
    logic [MISS_WIDTH-1:0]     limit_reg, limit_next;

    // Per-transaction action flags
    logic                      hb_flag_reg, hb_flag_next;
    logic                      init_flag_reg, init_flag_next;
    logic                      chg_flag_reg, chg_flag_next;
    logic                      rc_flag_reg, rc_flag_next;
    logic                      lost_flag_reg, lost_flag_next;

    // Captured time stamp
    logic [TIME_WIDTH-1:0]     now_reg, now_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic                      o_hb_reg, o_hb_next;
    logic                      o_init_reg, o_init_next;
    logic                      o_chg_reg, o_chg_next;
    logic                      o_rc_reg, o_rc_next;
    logic                      o_lost_reg, o_lost_next;
    logic                      o_conn_reg, o_conn_next;
    logic                      o_alive_reg, o_alive_next;
    logic [MISS_WIDTH-1:0]     o_miss_reg, o_miss_next;

    // Shared add/compare unit
    logic [TIME_WIDTH-1:0]     alu_a;
    logic [TIME_WIDTH-1:0]     alu_b;
    logic                      alu_sub;
    logic [TIME_WIDTH:0]       alu_sum;
    logic [TIME_WIDTH-1:0]     alu_sat;
    logic                      alu_ge;

    logic                      in_accept;
    logic [MISS_WIDTH-1:0]     miss_inc;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Operand select for the shared unit
    always_comb
    begin
        alu_a   = now_reg;
        alu_b   = nhb_reg;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_CONN_ADD:
            begin
                alu_b = TIME_WIDTH'(hbi_reg);
            end
            S_NRC_ADD:
            begin
                alu_b = TIME_WIDTH'(rci_reg);
            end
            S_RC_CMP:
            begin
                alu_b   = nrc_reg;
                alu_sub = 1'b1;
            end
            S_HB_CMP:
            begin
                alu_sub = 1'b1;
            end
            S_HB_STEP:
            begin
                alu_a = nhb_reg;
                alu_b = TIME_WIDTH'(hbi_reg);
            end
            default:
            begin
                alu_a = now_reg;
            end
        endcase
    end

    // Add with saturation, or subtract for a >= b (carry out = no borrow)
    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {TIME_WIDTH{alu_sub}}}
                     + (TIME_WIDTH+1)'(alu_sub);
    assign alu_sat = alu_sum[TIME_WIDTH] ? '1 : alu_sum[TIME_WIDTH-1:0];
    assign alu_ge  = alu_sum[TIME_WIDTH];

    // Saturating miss increment for one overdue interval
    assign miss_inc = (awaiting_reg && (misses_reg != MISS_MAX))
                      ? misses_reg + MISS_WIDTH'(1) : misses_reg;

    // Sequencer: next state and register updates
    always_comb
    begin
        state_next     = state_reg;
        conn_next      = conn_reg;
        alive_next     = alive_reg;
        awaiting_next  = awaiting_reg;
        misses_next    = misses_reg;
        nhb_next       = nhb_reg;
        nrc_next       = nrc_reg;
        hbi_next       = hbi_reg;
        rci_next       = rci_reg;
        limit_next     = limit_reg;
        hb_flag_next   = hb_flag_reg;
        init_flag_next = init_flag_reg;
        chg_flag_next  = chg_flag_reg;
        rc_flag_next   = rc_flag_reg;
        lost_flag_next = lost_flag_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg && out_stall;
        o_hb_next      = o_hb_reg;
        o_init_next    = o_init_reg;
        o_chg_next     = o_chg_reg;
        o_rc_next      = o_rc_reg;
        o_lost_next    = o_lost_reg;
        o_conn_next    = o_conn_reg;
        o_alive_next   = o_alive_reg;
        o_miss_next    = o_miss_reg;

        // Configuration writes; unused index is ignored
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HEARTBEAT_INTERVAL: hbi_next   = cfg_data;
                CFG_RECONNECT_INTERVAL: rci_next   = cfg_data;
                CFG_MISS_LIMIT:         limit_next = cfg_data[MISS_WIDTH-1:0];
                default:                ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    now_next       = now_ms;
                    hb_flag_next   = 1'b0;
                    init_flag_next = 1'b0;
                    chg_flag_next  = 1'b0;
                    rc_flag_next   = 1'b0;
                    lost_flag_next = 1'b0;
                    unique case (op_t'(operation))
                        OP_CONNECT:
                        begin
                            conn_next      = 1'b1;
                            alive_next     = 1'b0;
                            misses_next    = '0;
                            awaiting_next  = 1'b1;
                            nrc_next       = '0;
                            hb_flag_next   = 1'b1;
                            init_flag_next = 1'b1;
                            chg_flag_next  = 1'b1;
                            state_next     = S_CONN_ADD;
                        end
                        OP_RESPONSE:
                        begin
                            if (conn_reg)
                            begin
                                chg_flag_next = !alive_reg || (misses_reg != '0);
                                alive_next    = 1'b1;
                                misses_next   = '0;
                                awaiting_next = 1'b0;
                            end
                            state_next = S_DONE;
                        end
                        OP_DISCONNECT:
                        begin
                            chg_flag_next = conn_reg || alive_reg;
                            conn_next     = 1'b0;
                            alive_next    = 1'b0;
                            awaiting_next = 1'b0;
                            nhb_next      = '0;
                            state_next    = S_NRC_ADD;
                        end
                        OP_POLL:
                        begin
                            state_next = conn_reg ? S_HB_CMP : S_RC_CMP;
                        end
                    endcase
                end
            end

            // Heartbeat deadline after connect
            S_CONN_ADD:
            begin
                nhb_next   = alu_sat;
                state_next = S_DONE;
            end

            // Reconnect deadline after a drop or a reconnect request
            S_NRC_ADD:
            begin
                nrc_next   = alu_sat;
                state_next = S_DONE;
            end

            // Disconnected poll: reconnect when due
            S_RC_CMP:
            begin
                if (alu_ge)
                begin
                    rc_flag_next = 1'b1;
                    state_next   = S_NRC_ADD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Connected poll: is another heartbeat interval overdue
            S_HB_CMP:
            begin
                state_next = alu_ge ? S_HB_STEP : S_DONE;
            end

            // One overdue interval: count the miss, then drop or send
            S_HB_STEP:
            begin
                misses_next = miss_inc;
                if (miss_inc >= limit_reg)
                begin
                    conn_next      = 1'b0;
                    alive_next     = 1'b0;
                    awaiting_next  = 1'b0;
                    nhb_next       = '0;
                    hb_flag_next   = 1'b0;
                    lost_flag_next = 1'b1;
                    chg_flag_next  = 1'b1;
                    state_next     = S_NRC_ADD;
                end
                else
                begin
                    awaiting_next = 1'b1;
                    nhb_next      = alu_sat;
                    hb_flag_next  = 1'b1;
                    state_next    = S_HB_CMP;
                end
            end

            // Hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_hb_next      = hb_flag_reg;
                    o_init_next    = init_flag_reg;
                    o_chg_next     = chg_flag_reg;
                    o_rc_next      = rc_flag_reg;
                    o_lost_next    = lost_flag_reg;
                    o_conn_next    = conn_reg;
                    o_alive_next   = alive_reg;
                    o_miss_next    = misses_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            conn_reg      <= 1'b0;
            alive_reg     <= 1'b0;
            awaiting_reg  <= 1'b0;
            misses_reg    <= '0;
            nhb_reg       <= '0;
            nrc_reg       <= '0;
            hbi_reg       <= HEARTBEAT_INTERVAL_RST;
            rci_reg       <= RECONNECT_INTERVAL_RST;
            limit_reg     <= MISS_LIMIT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            conn_reg      <= conn_next;
            alive_reg     <= alive_next;
            awaiting_reg  <= awaiting_next;
            misses_reg    <= misses_next;
            nhb_reg       <= nhb_next;
            nrc_reg       <= nrc_next;
            hbi_reg       <= hbi_next;
            rci_reg       <= rci_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        hb_flag_reg   <= hb_flag_next;
        init_flag_reg <= init_flag_next;
        chg_flag_reg  <= chg_flag_next;
        rc_flag_reg   <= rc_flag_next;
        lost_flag_reg <= lost_flag_next;
        o_hb_reg      <= o_hb_next;
        o_init_reg    <= o_init_next;
        o_chg_reg     <= o_chg_next;
        o_rc_reg      <= o_rc_next;
        o_lost_reg    <= o_lost_next;
        o_conn_reg    <= o_conn_next;
        o_alive_reg   <= o_alive_next;
        o_miss_reg    <= o_miss_next;
    end

    // Output ports
    assign out_valid           = out_valid_reg;
    assign send_heartbeat      = o_hb_reg;
    assign send_initial_status = o_init_reg;
    assign connection_changed  = o_chg_reg;
    assign reconnect_request   = o_rc_reg;
    assign heartbeat_lost      = o_lost_reg;
    assign is_connected        = o_conn_reg;
    assign is_alive            = o_alive_reg;
    assign miss_count          = o_miss_reg;

    // Checks
    a_lost_drops_link: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && heartbeat_lost |-> !is_connected && !send_heartbeat)
        else $error("lost heartbeat with link still up or send requested");

    a_init_on_connect: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_initial_status |-> is_connected && send_heartbeat)
        else $error("initial status without connect");

    a_reconnect_when_down: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reconnect_request |-> !is_connected && !heartbeat_lost)
        else $error("reconnect requested while connected");

    a_catchup_connected: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HB_CMP || state_reg == S_HB_STEP |-> conn_reg)
        else $error("heartbeat catch-up while disconnected");

endmodule : heartbeat_keepalive_supervisor
`default_nettype wire
